// ----- hdl/rbae_pkg.sv -----
// Shared widths and pipeline control type for the rotated box extents block.
package rbae_pkg;

  localparam int QUAT_W  = 16;  // quaternion component width
  localparam int HALF_W  = 16;  // box half-extent field width
  localparam int OUT_W   = 17;  // bounding box extent field width
  localparam int PROD_W  = 2 * QUAT_W;  // one quaternion product
  localparam int ENTRY_W = PROD_W + 2;  // signed rotation matrix entry
  localparam int MAG_W   = PROD_W + 1;  // magnitude of one entry

  // Load enables for the stages held inside each row unit.
  typedef struct packed {
    logic load_prod;
    logic load_sum;
    logic load_out;
  } rbae_adv_t;

endpackage

// ----- hdl/rbae_row.sv -----
// One world axis: weight the entry magnitudes by the half-extents, sum, round, saturate.
module rbae_row #(
  parameter int EXTENT_WIDTH   = 16,
  parameter int QUAT_FRAC_BITS = 15
) (
  input  logic                                          clk,
  input  rbae_pkg::rbae_adv_t                           adv,
  input  logic [2:0][rbae_pkg::MAG_W-1:0]               mag,
  input  logic [2:0][rbae_pkg::HALF_W-1:0]              half,
  output logic [rbae_pkg::OUT_W-1:0]                    extent
);
  import rbae_pkg::*;

  localparam int TERM_W   = MAG_W + HALF_W;
  localparam int RAW_W    = TERM_W + 2;
  localparam int SHIFT    = 2 * QUAT_FRAC_BITS;
  localparam int SUM_W    = ((SHIFT > RAW_W) ? SHIFT : RAW_W) + 1;
  localparam logic [SUM_W-1:0] ROUND_HALF = {{(SUM_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic [OUT_W-1:0] CAP = (EXTENT_WIDTH >= OUT_W - 1) ? {OUT_W{1'b1}} :
                                     OUT_W'((64'd1 << (EXTENT_WIDTH + 1)) - 64'd1);

  logic [2:0][TERM_W-1:0] term;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]       scaled;

  always_ff @(posedge clk) begin
    if (adv.load_prod) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= TERM_W'(mag[j]) * TERM_W'(half[j]);
      end
    end
    if (adv.load_sum) begin
      sum <= sum_next;
    end
    if (adv.load_out) begin
      extent <= (scaled > SUM_W'(CAP)) ? CAP : scaled[OUT_W-1:0];
    end
  end

  // Sum is never negative, so round half up before the shift.
  assign sum_next = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]) + ROUND_HALF;
  assign scaled   = sum >> SHIFT;

endmodule

// ----- hdl/rotated_box_aabb_extents.sv -----
// Top level: axis-aligned half-extents of a box rotated by a quaternion.
//
//   channel | handshake           | fields
//   --------+---------------------+------------------------------------------------
//   in      | in_valid / in_stall | quat_w quat_x quat_y quat_z half_x half_y half_z
//   out     | out_valid/out_stall | extent_x extent_y extent_z
//
// One item per cycle sustained while the output is not stalled; each item spends six register stages in the
// pipe (input, products, matrix magnitudes, weighted terms, sum, saturate).
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the output holds every full stage; empty stages still fill, so
// bubbles squeeze out and nothing is dropped or repeated.
module rotated_box_aabb_extents #(
  parameter int EXTENT_WIDTH   = 16,
  parameter int QUAT_FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rbae_pkg::QUAT_W-1:0]   quat_w,
  input  logic signed [rbae_pkg::QUAT_W-1:0]   quat_x,
  input  logic signed [rbae_pkg::QUAT_W-1:0]   quat_y,
  input  logic signed [rbae_pkg::QUAT_W-1:0]   quat_z,
  input  logic        [rbae_pkg::HALF_W-1:0]   half_x,
  input  logic        [rbae_pkg::HALF_W-1:0]   half_y,
  input  logic        [rbae_pkg::HALF_W-1:0]   half_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [rbae_pkg::OUT_W-1:0]    extent_x,
  output logic        [rbae_pkg::OUT_W-1:0]    extent_y,
  output logic        [rbae_pkg::OUT_W-1:0]    extent_z
);
  import rbae_pkg::*;

  // Only the low EXTENT_WIDTH bits of each half-extent take part.
  localparam logic [HALF_W-1:0] HALF_MASK = (EXTENT_WIDTH >= HALF_W) ? {HALF_W{1'b1}} :
                                            HALF_W'((64'd1 << EXTENT_WIDTH) - 64'd1);

  function automatic logic [MAG_W-1:0] entry_mag(input logic signed [ENTRY_W-1:0] v);
    logic [ENTRY_W-1:0] a;
    a = v[ENTRY_W-1] ? ENTRY_W'(-v) : ENTRY_W'(v);
    return a[MAG_W-1:0];
  endfunction

  // Stage valid bits and stage advance enables.
  logic v_a, v_b, v_c, v_d, v_e;
  logic en_a, en_b, en_c, en_d, en_e, en_out;

  // Stage A: captured item.
  logic signed [QUAT_W-1:0] qw_a, qx_a, qy_a, qz_a;
  logic [2:0][HALF_W-1:0]   half_a, half_b, half_c;

  // Stage B: the ten distinct quaternion products.
  logic signed [PROD_W-1:0] p_ww, p_xx, p_yy, p_zz;
  logic signed [PROD_W-1:0] p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  // Stage C: magnitudes of the rotation matrix entries, row by row.
  logic signed [ENTRY_W-1:0]           ent [3][3];
  logic [2:0][2:0][MAG_W-1:0]          mag_c;
  rbae_adv_t                           adv;

  // Advance chain: a stage moves when it is empty or the next one moves.
  assign en_out   = !out_valid || !out_stall;
  assign en_e     = !v_e || en_out;
  assign en_d     = !v_d || en_e;
  assign en_c     = !v_c || en_d;
  assign en_b     = !v_b || en_c;
  assign en_a     = !v_a || en_b;
  assign in_stall = !en_a;

  assign adv.load_prod = en_d;
  assign adv.load_sum  = en_e;
  assign adv.load_out  = en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      v_e       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a)   v_a       <= in_valid;
      if (en_b)   v_b       <= v_a;
      if (en_c)   v_c       <= v_b;
      if (en_d)   v_d       <= v_c;
      if (en_e)   v_e       <= v_d;
      if (en_out) out_valid <= v_e;
    end
  end

  // Payload: hold while the stage is stalled, advance otherwise.
  always_ff @(posedge clk) begin
    if (en_a) begin
      qw_a      <= quat_w;
      qx_a      <= quat_x;
      qy_a      <= quat_y;
      qz_a      <= quat_z;
      half_a[0] <= half_x & HALF_MASK;
      half_a[1] <= half_y & HALF_MASK;
      half_a[2] <= half_z & HALF_MASK;
    end
    if (en_b) begin
      p_ww   <= qw_a * qw_a;
      p_xx   <= qx_a * qx_a;
      p_yy   <= qy_a * qy_a;
      p_zz   <= qz_a * qz_a;
      p_xy   <= qx_a * qy_a;
      p_xz   <= qx_a * qz_a;
      p_yz   <= qy_a * qz_a;
      p_wx   <= qw_a * qx_a;
      p_wy   <= qw_a * qy_a;
      p_wz   <= qw_a * qz_a;
      half_b <= half_a;
    end
    if (en_c) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mag_c[i][j] <= entry_mag(ent[i][j]);
        end
      end
      half_c <= half_b;
    end
  end

  // Rotation matrix of q*v*q' in its general (non-normalized) form.
  always_comb begin
    ent[0][0] = ENTRY_W'(p_ww) + ENTRY_W'(p_xx) - ENTRY_W'(p_yy) - ENTRY_W'(p_zz);
    ent[1][1] = ENTRY_W'(p_ww) - ENTRY_W'(p_xx) + ENTRY_W'(p_yy) - ENTRY_W'(p_zz);
    ent[2][2] = ENTRY_W'(p_ww) - ENTRY_W'(p_xx) - ENTRY_W'(p_yy) + ENTRY_W'(p_zz);
    ent[0][1] = (ENTRY_W'(p_xy) - ENTRY_W'(p_wz)) <<< 1;
    ent[0][2] = (ENTRY_W'(p_xz) + ENTRY_W'(p_wy)) <<< 1;
    ent[1][0] = (ENTRY_W'(p_xy) + ENTRY_W'(p_wz)) <<< 1;
    ent[1][2] = (ENTRY_W'(p_yz) - ENTRY_W'(p_wx)) <<< 1;
    ent[2][0] = (ENTRY_W'(p_xz) - ENTRY_W'(p_wy)) <<< 1;
    ent[2][1] = (ENTRY_W'(p_yz) + ENTRY_W'(p_wx)) <<< 1;
  end

  // Stages D, E and output live in the per-axis row units.
  rbae_row #(
    .EXTENT_WIDTH  (EXTENT_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_row_x (
    .clk   (clk),
    .adv   (adv),
    .mag   (mag_c[0]),
    .half  (half_c),
    .extent(extent_x)
  );

  rbae_row #(
    .EXTENT_WIDTH  (EXTENT_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_row_y (
    .clk   (clk),
    .adv   (adv),
    .mag   (mag_c[1]),
    .half  (half_c),
    .extent(extent_y)
  );

  rbae_row #(
    .EXTENT_WIDTH  (EXTENT_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_row_z (
    .clk   (clk),
    .adv   (adv),
    .mag   (mag_c[2]),
    .half  (half_c),
    .extent(extent_z)
  );

endmodule

// ----- hdl/rbae_checker.sv -----
// Port-level checks for the rotated box extents block, bound to the top level.
module rbae_checker #(
  parameter int EXTENT_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rbae_pkg::OUT_W-1:0]    extent_x,
  input logic [rbae_pkg::OUT_W-1:0]    extent_y,
  input logic [rbae_pkg::OUT_W-1:0]    extent_z
);
  import rbae_pkg::*;

  localparam logic [OUT_W-1:0] CAP = (EXTENT_WIDTH >= OUT_W - 1) ? {OUT_W{1'b1}} :
                                     OUT_W'((64'd1 << (EXTENT_WIDTH + 1)) - 64'd1);

  // A stalled result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(extent_x) && $stable(extent_y) &&
                               $stable(extent_z))
    else $error("stalled result changed");

  // Reset empties the pipe.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // With no result waiting, the pipe must be able to take an item.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  // Results never exceed the saturation limit.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> extent_x <= CAP && extent_y <= CAP && extent_z <= CAP)
    else $error("extent above saturation limit");

endmodule

bind rotated_box_aabb_extents rbae_checker #(.EXTENT_WIDTH(EXTENT_WIDTH)) u_rbae_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .extent_x (extent_x),
  .extent_y (extent_y),
  .extent_z (extent_z)
);

// ----- test/tb.sv -----
// Testbench for rotated_box_aabb_extents: directed table plus random boxes, checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbae_pkg::*;

  // Build the block with its default sizes; the predictor uses the same values.
  localparam int EXT_BITS  = 16;
  localparam int FRAC_BITS = 15;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // No accepted item on either channel for this many cycles ends the run.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the one long output hold that backs the pipe up.
  localparam int LONG_HOLD = 400;
  // Extra cycles after the last result, well past the six pipe stages.
  localparam int DRAIN_CYCLES = 16;

  localparam int N_DIR        = 20;
  localparam int N_SEGMENTS   = 18;
  localparam int SEGMENT_SIZE = 100;
  localparam int PRESSURE_SEG = 5;

  // One input item: quaternion plus local half-extents.
  typedef struct packed {
    logic signed [QUAT_W-1:0] qw;
    logic signed [QUAT_W-1:0] qx;
    logic signed [QUAT_W-1:0] qy;
    logic signed [QUAT_W-1:0] qz;
    logic        [HALF_W-1:0] hx;
    logic        [HALF_W-1:0] hy;
    logic        [HALF_W-1:0] hz;
  } box_item_t;

  // World-axis half-extents, index 0 is x.
  typedef logic [0:2][OUT_W-1:0] extents_t;

  // Directed row: the item, and the extents when they are obvious by hand.
  typedef struct packed {
    box_item_t item;
    logic      known;
    extents_t  ext;
  } dir_row_t;

  localparam extents_t EXT_NONE = '0;

  logic clk;
  logic rst;

  logic              in_valid;
  logic              in_stall;
  logic [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;
  logic [HALF_W-1:0] half_x, half_y, half_z;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OUT_W-1:0]  extent_x, extent_y, extent_z;

  // Expected extents of every accepted box, oldest first.
  extents_t pending_extents [$];

  dir_row_t dir_table [N_DIR];

  int errors        = 0;
  int boxes_sent    = 0;
  int extents_seen  = 0;
  int saturated     = 0;
  int tx_gap_pct    = 0;
  int rx_gap_pct    = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int rx_hold_left  = 0;
  int rx_burst_left = 0;
  int quiet_cycles  = 0;

  rotated_box_aabb_extents #(
    .EXTENT_WIDTH  (EXT_BITS),
    .QUAT_FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .half_x   (half_x),
    .half_y   (half_y),
    .half_z   (half_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .extent_x (extent_x),
    .extent_y (extent_y),
    .extent_z (extent_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the bounding half-extents as sum_j |R[i][j]| * h[j], where R is
  // the unnormalized rotation matrix of q, then round half up and saturate.
  function automatic extents_t rotated_extents(box_item_t s);
    longint          w, x, y, z;
    longint          rot [3][3];
    longint unsigned h [3];
    longint unsigned acc, mag, lim, ext_mask;
    extents_t        e;
    w = signed'(s.qw);
    x = signed'(s.qx);
    y = signed'(s.qy);
    z = signed'(s.qz);
    ext_mask = (64'd1 << EXT_BITS) - 64'd1;
    h[0] = s.hx & ext_mask;
    h[1] = s.hy & ext_mask;
    h[2] = s.hz & ext_mask;
    rot[0][0] = w * w + x * x - y * y - z * z;
    rot[0][1] = 2 * (x * y - w * z);
    rot[0][2] = 2 * (x * z + w * y);
    rot[1][0] = 2 * (x * y + w * z);
    rot[1][1] = w * w - x * x + y * y - z * z;
    rot[1][2] = 2 * (y * z - w * x);
    rot[2][0] = 2 * (x * z - w * y);
    rot[2][1] = 2 * (y * z + w * x);
    rot[2][2] = w * w - x * x - y * y + z * z;
    lim = (64'd1 << (EXT_BITS + 1)) - 64'd1;
    if (lim > 64'(OUT_MAX)) lim = 64'(OUT_MAX);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        mag = (rot[i][j] < 0) ? longint'(-rot[i][j]) : longint'(rot[i][j]);
        acc += mag * h[j];
      end
      acc = (acc + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      if (acc > lim) acc = lim;
      e[i] = acc[OUT_W-1:0];
    end
    return e;
  endfunction

  // Pick a component from the values where rotations are exact or extreme.
  function automatic logic [QUAT_W-1:0] notable_comp();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'hC000;
      3: return 16'h5A82;
      4: return 16'hA57E;
      5: return 16'h7FFF;
      6: return 16'h8000;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [HALF_W-1:0] random_half();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return HALF_W'($urandom());
      4, 5, 6:    return HALF_W'($urandom_range(0, 255));
      7:          return 16'hFFFF;
      8:          return 16'h8000;
      default:    return HALF_W'($urandom_range(0, 1));
    endcase
  endfunction

  // Half unit quaternions with random axes; the rest exact, extreme or raw noise.
  function automatic box_item_t random_box();
    box_item_t s;
    real       c [4];
    real       norm;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      for (int i = 0; i < 4; i++)
        c[i] = ($itor($urandom_range(0, 65535)) - 32767.5) / 32767.5;
      norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
      if (norm < 0.01) begin
        c[0] = 1.0; c[1] = 0.0; c[2] = 0.0; c[3] = 0.0; norm = 1.0;
      end
      s.qw = QUAT_W'($rtoi(c[0] / norm * 32767.0));
      s.qx = QUAT_W'($rtoi(c[1] / norm * 32767.0));
      s.qy = QUAT_W'($rtoi(c[2] / norm * 32767.0));
      s.qz = QUAT_W'($rtoi(c[3] / norm * 32767.0));
    end else if (pick < 65) begin
      s.qw = notable_comp();
      s.qx = notable_comp();
      s.qy = notable_comp();
      s.qz = notable_comp();
    end else begin
      s.qw = QUAT_W'($urandom());
      s.qx = QUAT_W'($urandom());
      s.qy = QUAT_W'($urandom());
      s.qz = QUAT_W'($urandom());
    end
    s.hx = random_half();
    s.hy = random_half();
    s.hz = random_half();
    return s;
  endfunction

  // Offer one box, optionally after a random gap, and hold it until taken.
  // Leave valid high on return so the next item follows without a bubble.
  task automatic offer_box(input box_item_t s, input extents_t want);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_w   <= s.qw;
    quat_x   <= s.qx;
    quat_y   <= s.qy;
    quat_z   <= s.qz;
    half_x   <= s.hx;
    half_y   <= s.hy;
    half_z   <= s.hz;
    do @(posedge clk); while (in_stall);
    pending_extents.push_back(want);
    boxes_sent++;
  endtask

  // Output side: random stall bursts, plus one long hold on request.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall    <= 1'b1;
      hold_served  <= hold_asked;
      rx_hold_left <= LONG_HOLD - 1;
    end else if (rx_burst_left > 0) begin
      out_stall     <= 1'b1;
      rx_burst_left <= rx_burst_left - 1;
    end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
      out_stall     <= 1'b1;
      rx_burst_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_extents
    extents_t got, want;
    string    axes;
    axes = "xyz";
    if (!rst && out_valid && !out_stall) begin
      got = {extent_x, extent_y, extent_z};
      extents_seen++;
      if (pending_extents.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got x=%0d y=%0d z=%0d",
                 $time, got[0], got[1], got[2]);
      end else begin
        want = pending_extents.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got[i] !== want[i]) begin
            errors++;
            $display("%0t: extent_%c mismatch: expected %0d, got %0d",
                     $time, axes[i], want[i], got[i]);
          end
          if (got[i] == OUT_MAX) saturated++;
        end
      end
    end
  end

  // Abort when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_extents.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    box_item_t s;
    extents_t  want;

    rst      = 1'b1;
    in_valid = 1'b0;
    quat_w   = '0;
    quat_x   = '0;
    quat_y   = '0;
    quat_z   = '0;
    half_x   = '0;
    half_y   = '0;
    half_z   = '0;

    // Rows: quaternion (w x y z), half-extents (x y z), hand-known flag, extents.
    dir_table = '{
      // zero quaternion collapses the box
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{17'd0, 17'd0, 17'd0}},
      // zero box under near-identity
      '{'{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        1'b1, '{17'd0, 17'd0, 17'd0}},
      // exact identity from each negative full-scale axis
      '{'{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h3039},
        1'b1, '{17'h0FFFF, 17'h00001, 17'h03039}},
      '{'{16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h1234, 16'h5678, 16'h9ABC},
        1'b1, '{17'h01234, 17'h05678, 17'h09ABC}},
      '{'{16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h1234, 16'h5678, 16'h9ABC},
        1'b1, '{17'h01234, 17'h05678, 17'h09ABC}},
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h1234, 16'h5678, 16'h9ABC},
        1'b1, '{17'h01234, 17'h05678, 17'h09ABC}},
      // |q|^2 = 4 with full boxes: every axis saturates
      '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF}},
      // 120 degrees about the diagonal permutes the axes
      '{'{16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h0064, 16'h00C8, 16'h012C},
        1'b1, '{17'h0012C, 17'h00064, 17'h000C8}},
      '{'{16'hC000, 16'hC000, 16'hC000, 16'hC000, 16'h0064, 16'h00C8, 16'h012C},
        1'b1, '{17'h0012C, 17'h00064, 17'h000C8}},
      // quarter-scale identity: x is exactly one half and rounds up
      '{'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0001, 16'h0003},
        1'b1, '{17'd1, 17'd0, 17'd1}},
      '{'{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b0, EXT_NONE},
      '{'{16'h5A82, 16'h0000, 16'h0000, 16'h5A82, 16'hFFFF, 16'h0000, 16'h0000},
        1'b0, EXT_NONE},
      '{'{16'h7642, 16'h30FC, 16'h0000, 16'h0000, 16'h1000, 16'h2000, 16'h3000},
        1'b0, EXT_NONE},
      '{'{16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b0, EXT_NONE},
      '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b0, EXT_NONE},
      '{'{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b0, EXT_NONE},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b0, EXT_NONE},
      '{'{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF},
        1'b0, EXT_NONE},
      '{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h0000},
        1'b0, EXT_NONE},
      '{'{16'h5A82, 16'h5A82, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000},
        1'b0, EXT_NONE}
    };

    // Hold reset, then release it once for good.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table with light idling on both sides.
    tx_gap_pct = 20;
    rx_gap_pct <= 15;
    for (int k = 0; k < N_DIR; k++) begin
      want = dir_table[k].known ? dir_table[k].ext : rotated_extents(dir_table[k].item);
      offer_box(dir_table[k].item, want);
    end

    // Random boxes in segments, each with its own idling mix.
    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      if (seg >= N_SEGMENTS - 2) begin
        // Stream the tail with no idling on either side.
        tx_gap_pct = 0;
        rx_gap_pct <= 0;
      end else if (seg == PRESSURE_SEG) begin
        // Hold the output off for a long stretch while boxes keep coming.
        tx_gap_pct = 0;
        rx_gap_pct <= 0;
        hold_asked <= hold_asked + 1;
      end else begin
        case (seg % 4)
          0: begin tx_gap_pct = 0;  rx_gap_pct <= 0;  end
          1: begin tx_gap_pct = 30; rx_gap_pct <= 30; end
          2: begin tx_gap_pct = 5;  rx_gap_pct <= 40; end
          default: begin tx_gap_pct = 40; rx_gap_pct <= 5; end
        endcase
      end
      for (int k = 0; k < SEGMENT_SIZE; k++) begin
        s = random_box();
        offer_box(s, rotated_extents(s));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then a few more cycles.
    while (pending_extents.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d boxes (%0d from the directed table) and %0d results,",
             boxes_sent, N_DIR, extents_seen);
    $display("with %0d saturated axes, random stalls and one long output hold; %0d errors.",
             saturated, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
